// ----- design/ssp_pkg.sv -----
// package for the snapshot segment planner: widths, record geometry, channel masks
// and the structs passed between the stages; no dependencies
`default_nettype none

package ssp_pkg;

    // record geometry
    localparam int REC_WORDS = 40;
    localparam int REC_BYTES = 4 * REC_WORDS;

    // field widths
    localparam int ADDR_W = 32;
    localparam int PTS_W  = 18;
    localparam int CH_W   = 3;
    localparam int SEG_W  = 25;
    localparam int MASK_W = 40;

    // derived widths
    localparam int WW   = PTS_W + $clog2(REC_WORDS);   // points times record words
    localparam int BW   = WW + 2;                      // points times record bytes
    localparam int END_W = ADDR_W + 1;                 // base plus length, no wrap
    localparam int HEAD_W  = ADDR_W - 2;               // latch minus base, in words
    localparam int FIRST_W = END_W - 2;                // end minus latch, in words

    // register map, byte address bit 2 selects the register
    localparam int PADDR_W = 3;
    localparam logic REG_BASE   = 1'b0;
    localparam logic REG_LENGTH = 1'b1;

    localparam logic [ADDR_W-1:0] BASE_RESET   = 32'h1000_0000;
    localparam logic [ADDR_W-1:0] LENGTH_RESET = 32'h01E8_4800;

    // channel codes
    localparam logic [CH_W-1:0] CH_1 = 3'd1;
    localparam logic [CH_W-1:0] CH_2 = 3'd2;
    localparam logic [CH_W-1:0] CH_3 = 3'd3;
    localparam logic [CH_W-1:0] CH_4 = 3'd4;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [END_W-1:0]  t_end;
    typedef logic [WW-1:0]     t_words;
    typedef logic [BW-1:0]     t_bytes;
    typedef logic [SEG_W-1:0]  t_seg_words;
    typedef logic [MASK_W-1:0] t_mask;

    typedef struct packed {
        t_addr base;
        t_addr length;
    } t_cfg;

    // after stage 1: products and channel decode
    typedef struct packed {
        t_addr      latch;
        t_words     pre_w;
        t_words     post_w;
        t_seg_words sum_w;
        t_bytes     pre_b;
        t_bytes     post_b;
        t_addr      base;
        t_end       end_a;
        t_mask      mask;
        logic       bad;
    } t_s1;

    // after stage 2: wrap tests and raw part lengths
    typedef struct packed {
        t_addr              latch;
        t_addr              start_a;
        t_addr              base;
        t_end               end_a;
        t_words             pre_w;
        t_words             post_w;
        t_seg_words         sum_w;
        logic [HEAD_W-1:0]  head;
        logic [FIRST_W-1:0] first;
        logic               pre_wrap;
        logic               post_wrap;
        t_mask              mask;
        logic               bad;
    } t_s2;

    // after stage 3: everything the sequencer needs to lay out the segments
    typedef struct packed {
        t_addr      latch;
        t_addr      start_a;
        t_addr      base;
        t_end       end_a;
        t_words     pre_w;
        t_words     post_w;
        t_seg_words sum_w;
        t_seg_words head_w;
        t_seg_words first_w;
        t_words     tail;
        t_words     second;
        logic       pre_wrap;
        logic       three;
        t_mask      mask;
        logic       bad;
    } t_s3;

    function automatic t_mask chan_mask(input logic [CH_W-1:0] ch);
        t_mask m;
        unique case (ch)
            CH_1:    m = 40'h00_0000_03FF;
            CH_2:    m = 40'h00_0003_FC03;
            CH_3:    m = 40'h00_03FC_0003;
            CH_4:    m = 40'h03_FC00_0003;
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

// ----- design/ssp_regs.sv -----
// apb register file for the buffer base and length
// depends on ssp_pkg
`default_nettype none

module ssp_regs (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [ssp_pkg::PADDR_W-1:0]  paddr,
    input  wire  [ssp_pkg::ADDR_W-1:0]   pwdata,
    output logic [ssp_pkg::ADDR_W-1:0]   prdata,
    output logic                         pready,
    output ssp_pkg::t_cfg                o_cfg
);

    ssp_pkg::t_addr r_base;
    ssp_pkg::t_addr r_length;
    logic           wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base   <= ssp_pkg::BASE_RESET;
            r_length <= ssp_pkg::LENGTH_RESET;
        end else if (wr_en) begin
            unique case (paddr[2])
                ssp_pkg::REG_BASE:   r_base   <= pwdata;
                ssp_pkg::REG_LENGTH: r_length <= pwdata;
                default:             r_base   <= r_base;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            ssp_pkg::REG_BASE:   prdata = r_base;
            ssp_pkg::REG_LENGTH: prdata = r_length;
            default:             prdata = '0;
        endcase
    end

    assign o_cfg.base   = r_base;
    assign o_cfg.length = r_length;

endmodule

`default_nettype wire

// ----- design/ssp_pipe.sv -----
// three-stage planning pipeline: products, wrap tests, clamped part lengths
// depends on ssp_pkg
`default_nettype none

module ssp_pipe (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_start,
    output logic                        o_busy,
    input  wire  [ssp_pkg::ADDR_W-1:0]  i_latch_addr,
    input  wire  [ssp_pkg::PTS_W-1:0]   i_pre_points,
    input  wire  [ssp_pkg::PTS_W-1:0]   i_post_points,
    input  wire  [ssp_pkg::CH_W-1:0]    i_channel,
    input  ssp_pkg::t_cfg               i_cfg,
    input  wire                         i_take,
    output logic                        o_valid,
    output ssp_pkg::t_s3                o_s3
);

    logic         r_v1, r_v2, r_v3;
    ssp_pkg::t_s1 r_s1, n_s1;
    ssp_pkg::t_s2 r_s2, n_s2;
    ssp_pkg::t_s3 r_s3, n_s3;
    logic         free1, free2, free3, acc;

    // a stage may load when it is empty or its contents move on
    assign free3  = !r_v3 || i_take;
    assign free2  = !r_v2 || free3;
    assign free1  = !r_v1 || free2;
    assign o_busy = !free1;
    assign acc    = i_start && free1;

    // stage 1: record products and channel decode
    always_comb begin
        n_s1.latch  = i_latch_addr;
        n_s1.pre_w  = ssp_pkg::WW'(i_pre_points) * ssp_pkg::WW'(ssp_pkg::REC_WORDS);
        n_s1.post_w = ssp_pkg::WW'(i_post_points) * ssp_pkg::WW'(ssp_pkg::REC_WORDS);
        n_s1.sum_w  = (ssp_pkg::SEG_W'(i_pre_points) + ssp_pkg::SEG_W'(i_post_points))
                      * ssp_pkg::SEG_W'(ssp_pkg::REC_WORDS);
        n_s1.pre_b  = ssp_pkg::BW'(i_pre_points) * ssp_pkg::BW'(ssp_pkg::REC_BYTES);
        n_s1.post_b = ssp_pkg::BW'(i_post_points) * ssp_pkg::BW'(ssp_pkg::REC_BYTES);
        n_s1.base   = i_cfg.base;
        n_s1.end_a  = ssp_pkg::END_W'(i_cfg.base) + ssp_pkg::END_W'(i_cfg.length);
        n_s1.mask   = ssp_pkg::chan_mask(i_channel);
        n_s1.bad    = !(i_channel == ssp_pkg::CH_1 || i_channel == ssp_pkg::CH_2 ||
                        i_channel == ssp_pkg::CH_3 || i_channel == ssp_pkg::CH_4);
    end

    // stage 2: wrap tests and distances to the buffer edges
    always_comb begin
        logic [ssp_pkg::END_W-1:0] d_head;
        logic [ssp_pkg::END_W-1:0] d_first;
        d_head  = ssp_pkg::END_W'(r_s1.latch) - ssp_pkg::END_W'(r_s1.base);
        d_first = r_s1.end_a - ssp_pkg::END_W'(r_s1.latch);
        n_s2.latch     = r_s1.latch;
        n_s2.start_a   = r_s1.latch - ssp_pkg::ADDR_W'(r_s1.pre_b);
        n_s2.base      = r_s1.base;
        n_s2.end_a     = r_s1.end_a;
        n_s2.pre_w     = r_s1.pre_w;
        n_s2.post_w    = r_s1.post_w;
        n_s2.sum_w     = r_s1.sum_w;
        n_s2.mask      = r_s1.mask;
        n_s2.bad       = r_s1.bad;
        n_s2.pre_wrap  = ssp_pkg::END_W'(r_s1.latch) <
                         (ssp_pkg::END_W'(r_s1.base) + ssp_pkg::END_W'(r_s1.pre_b));
        n_s2.post_wrap = (ssp_pkg::END_W'(r_s1.latch) + ssp_pkg::END_W'(r_s1.post_b)) >
                         r_s1.end_a;
        // latch below base or trigger past the end give an empty part
        n_s2.head  = (r_s1.latch > r_s1.base) ? d_head[ssp_pkg::ADDR_W-1:2] : '0;
        n_s2.first = (r_s1.end_a > ssp_pkg::END_W'(r_s1.latch)) ?
                     d_first[ssp_pkg::END_W-1:2] : '0;
    end

    // stage 3: remaining part lengths, clamped at zero
    always_comb begin
        n_s3.latch    = r_s2.latch;
        n_s3.start_a  = r_s2.start_a;
        n_s3.base     = r_s2.base;
        n_s3.end_a    = r_s2.end_a;
        n_s3.pre_w    = r_s2.pre_w;
        n_s3.post_w   = r_s2.post_w;
        n_s3.sum_w    = r_s2.sum_w;
        n_s3.head_w   = ssp_pkg::SEG_W'(r_s2.head);
        n_s3.first_w  = ssp_pkg::SEG_W'(r_s2.first);
        n_s3.tail     = (ssp_pkg::HEAD_W'(r_s2.pre_w) > r_s2.head) ?
                        (r_s2.pre_w - ssp_pkg::WW'(r_s2.head)) : '0;
        n_s3.second   = (ssp_pkg::FIRST_W'(r_s2.post_w) > r_s2.first) ?
                        (r_s2.post_w - ssp_pkg::WW'(r_s2.first)) : '0;
        n_s3.pre_wrap = r_s2.pre_wrap;
        n_s3.three    = r_s2.pre_wrap || r_s2.post_wrap;
        n_s3.mask     = r_s2.mask;
        n_s3.bad      = r_s2.bad;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (free1) r_v1 <= acc;
            if (free2) r_v2 <= r_v1;
            if (free3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc)            r_s1 <= n_s1;
        if (free2 && r_v1)  r_s2 <= n_s2;
        if (free3 && r_v2)  r_s3 <= n_s3;
    end

    assign o_valid = r_v3;
    assign o_s3    = r_s3;

    // a stalled last stage keeps its plan
    a_s3_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && !i_take |=> r_v3 && $stable(r_s3))
        else $error("stalled plan changed");

    // busy only when every stage is full and the output holds
    a_busy_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_busy |-> r_v1 && r_v2 && r_v3 && !i_take)
        else $error("busy with room in the pipeline");

endmodule

`default_nettype wire

// ----- design/ssp_seq.sv -----
// segment sequencer: lays out one or three segments and issues one per cycle
// depends on ssp_pkg
`default_nettype none

module ssp_seq (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    input  ssp_pkg::t_s3                 i_s3,
    output logic                         o_take,
    output logic                         o_seg_valid,
    output logic [ssp_pkg::ADDR_W-1:0]   o_seg_start,
    output logic [ssp_pkg::SEG_W-1:0]    o_seg_words,
    output logic [ssp_pkg::MASK_W-1:0]   o_word_mask,
    output logic                         o_bad_channel,
    output logic                         o_last
);

    ssp_pkg::t_addr     r_start [3];
    ssp_pkg::t_seg_words r_words [3];
    ssp_pkg::t_addr     n_start [3];
    ssp_pkg::t_seg_words n_words [3];
    ssp_pkg::t_mask     r_mask;
    logic               r_bad;
    logic               r_three;
    logic               r_pv;
    logic [1:0]         r_idx;
    logic               last_now;

    assign last_now = r_three ? (r_idx == 2'd2) : 1'b1;
    assign o_take   = !r_pv || last_now;

    always_comb begin
        n_start[0] = i_s3.start_a;
        n_words[0] = i_s3.sum_w;
        n_start[1] = i_s3.latch;
        n_words[1] = i_s3.first_w;
        n_start[2] = i_s3.base;
        n_words[2] = ssp_pkg::SEG_W'(i_s3.second);
        priority if (i_s3.pre_wrap) begin
            // buffer tail, buffer head up to the trigger, then post-trigger part
            n_start[0] = ssp_pkg::ADDR_W'(i_s3.end_a) -
                         (ssp_pkg::ADDR_W'(i_s3.tail) << 2);
            n_words[0] = ssp_pkg::SEG_W'(i_s3.tail);
            n_start[1] = i_s3.base;
            n_words[1] = i_s3.head_w;
            n_start[2] = i_s3.latch;
            n_words[2] = ssp_pkg::SEG_W'(i_s3.post_w);
        end else if (i_s3.three) begin
            n_words[0] = ssp_pkg::SEG_W'(i_s3.pre_w);
        end else begin
            n_words[0] = i_s3.sum_w;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv  <= 1'b0;
            r_idx <= 2'd0;
        end else if (o_take && i_valid) begin
            r_pv  <= 1'b1;
            r_idx <= 2'd0;
        end else if (r_pv) begin
            if (last_now) begin
                r_pv  <= 1'b0;
                r_idx <= 2'd0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_valid) begin
            r_start <= n_start;
            r_words <= n_words;
            r_mask  <= i_s3.mask;
            r_bad   <= i_s3.bad;
            r_three <= i_s3.three;
        end
    end

    assign o_seg_valid   = r_pv;
    assign o_seg_start   = r_start[r_idx];
    assign o_seg_words   = r_words[r_idx];
    assign o_word_mask   = r_bad ? '0 : r_mask;
    assign o_bad_channel = r_bad;
    assign o_last        = last_now;

    // a one-segment plan is always issued from slot zero
    a_single_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pv && !r_three |-> r_idx == 2'd0)
        else $error("single segment issued from wrong slot");

    // a three-segment plan runs without gaps
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pv && !last_now |=> r_pv && r_idx == $past(r_idx) + 2'd1)
        else $error("segment sequence broken");

endmodule

`default_nettype wire

// ----- design/snapshot_segment_planner_top.sv -----
// top level of the snapshot segment planner
// depends on ssp_pkg, ssp_regs, ssp_pipe and ssp_seq
`default_nettype none

// A readout request (trigger byte address, pre- and post-trigger record counts,
// channel) is taken at a clock edge with start high and busy low. It passes a
// three-stage planning pipeline and then leaves as one segment (no wrap) or
// three segments (wrap below the buffer start or past the buffer end), one
// transfer per cycle on o_seg_valid, with o_last on the final one. The plan for
// a request passes the stage registers and then the sequencer registers before
// its first segment is on the ports. Results cannot be held off, so the
// sequencer sets the pace: a request that wraps occupies the output for three
// segments, a request that does not wrap for one, and busy rises only when the
// pipeline is full behind a plan still being issued. Zero-length segments are
// still issued. A bad channel gives a zero word mask and o_bad_channel on every
// segment. The user writes buffer base and length over the apb port (base at
// 0x0, length at 0x4) only while the block is idle; the block does not enforce it.
module snapshot_segment_planner_top (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // request
    input  wire                          start,
    output logic                         busy,
    input  wire  [ssp_pkg::ADDR_W-1:0]   i_latch_addr,
    input  wire  [ssp_pkg::PTS_W-1:0]    i_pre_points,
    input  wire  [ssp_pkg::PTS_W-1:0]    i_post_points,
    input  wire  [ssp_pkg::CH_W-1:0]     i_channel,
    // segments
    output logic                         o_seg_valid,
    output logic [ssp_pkg::ADDR_W-1:0]   o_seg_start,
    output logic [ssp_pkg::SEG_W-1:0]    o_seg_words,
    output logic [ssp_pkg::MASK_W-1:0]   o_word_mask,
    output logic                         o_bad_channel,
    output logic                         o_last,
    // configuration
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [ssp_pkg::PADDR_W-1:0]  paddr,
    input  wire  [ssp_pkg::ADDR_W-1:0]   pwdata,
    output logic [ssp_pkg::ADDR_W-1:0]   prdata,
    output logic                         pready
);

    ssp_pkg::t_cfg cfg;
    ssp_pkg::t_s3  plan;
    logic          plan_valid;
    logic          plan_take;

    // buffer base and length registers
    ssp_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // planning pipeline, stalls only behind the sequencer
    ssp_pipe u_pipe (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .o_busy        (busy),
        .i_latch_addr  (i_latch_addr),
        .i_pre_points  (i_pre_points),
        .i_post_points (i_post_points),
        .i_channel     (i_channel),
        .i_cfg         (cfg),
        .i_take        (plan_take),
        .o_valid       (plan_valid),
        .o_s3          (plan)
    );

    // segment layout and issue, one transfer per cycle
    ssp_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (plan_valid),
        .i_s3          (plan),
        .o_take        (plan_take),
        .o_seg_valid   (o_seg_valid),
        .o_seg_start   (o_seg_start),
        .o_seg_words   (o_seg_words),
        .o_word_mask   (o_word_mask),
        .o_bad_channel (o_bad_channel),
        .o_last        (o_last)
    );

endmodule

`default_nettype wire

// ----- test/tb_snapshot_segment_planner_top.sv -----
// self-checking testbench for snapshot_segment_planner_top: readout requests in,
// planned read segments out, checked against an in-bench segment planner
// depends on ssp_pkg and the design files of snapshot_segment_planner_top
`timescale 1ns / 1ps

module tb_snapshot_segment_planner_top;
    import ssp_pkg::*;

    typedef logic [PTS_W-1:0] t_pts;
    typedef logic [CH_W-1:0]  t_ch;

    // one planned segment, as it should appear on the result ports
    typedef struct packed {
        t_addr      start_a;
        t_seg_words words;
        t_mask      mask;
        logic       bad;
        logic       last;
    } t_seg;

    // one readout request; typed rows carry their single segment written out by hand
    typedef struct packed {
        t_addr latch;
        t_pts  pre;
        t_pts  post;
        t_ch   ch;
        logic  typed;
        t_seg  seg;
    } t_request;

    // channel numbers outside 1 to 4
    localparam t_ch CH_INVALID_0 = 3'd0;
    localparam t_ch CH_INVALID_5 = 3'd5;
    localparam t_ch CH_INVALID_6 = 3'd6;
    localparam t_ch CH_INVALID_7 = 3'd7;

    localparam t_pts PTS_MAX = '1;

    // register byte addresses: register index sits on paddr bit 2
    localparam logic [PADDR_W-1:0] PADDR_BASE   = {REG_BASE, 2'b00};
    localparam logic [PADDR_W-1:0] PADDR_LENGTH = {REG_LENGTH, 2'b00};

    localparam int RESET_CYCLES   = 11;
    localparam int DRAIN_CYCLES   = 10;    // margin for the planning pipeline and up to 3 segments
    localparam int QUIET_LIMIT    = 5000;  // cycles without any transfer before giving up
    localparam int PHASES         = 6;
    localparam int PHASE_REQUESTS = 60;
    localparam int DIRECTED_COUNT = 20;

    // directed requests, all under the reset buffer window 0x1000_0000 .. 0x11E8_4800
    localparam t_request DIRECTED_ROWS [0:DIRECTED_COUNT-1] = '{
        // one segment per channel, expected values read straight off the window
        '{32'h1000_1000, 18'd0, 18'd0, CH_1, 1'b1,
          '{32'h1000_1000, 25'd0,   40'h00_0000_03FF, 1'b0, 1'b1}},
        '{32'h1000_1000, 18'd1, 18'd1, CH_2, 1'b1,
          '{32'h1000_0F60, 25'd80,  40'h00_0003_FC03, 1'b0, 1'b1}},
        '{32'h1000_2000, 18'd2, 18'd3, CH_3, 1'b1,
          '{32'h1000_1EC0, 25'd200, 40'h00_03FC_0003, 1'b0, 1'b1}},
        '{32'h1000_2000, 18'd0, 18'd5, CH_4, 1'b1,
          '{32'h1000_2000, 25'd200, 40'h03_FC00_0003, 1'b0, 1'b1}},
        // invalid channels: zero mask and the error flag
        '{32'h1000_2000, 18'd0, 18'd1, CH_INVALID_0, 1'b1,
          '{32'h1000_2000, 25'd40,  40'h0, 1'b1, 1'b1}},
        '{32'h1000_3000, 18'd1, 18'd0, CH_INVALID_5, 1'b1,
          '{32'h1000_2F60, 25'd40,  40'h0, 1'b1, 1'b1}},
        '{32'h1000_3000, 18'd0, 18'd0, CH_INVALID_6, 1'b1,
          '{32'h1000_3000, 25'd0,   40'h0, 1'b1, 1'b1}},
        '{32'h1000_3000, 18'd2, 18'd2, CH_INVALID_7, 1'b1,
          '{32'h1000_2EC0, 25'd160, 40'h0, 1'b1, 1'b1}},
        // window starting exactly on the buffer start: no wrap
        '{32'h1000_0640, 18'd10, 18'd0, CH_1, 1'b0, '0},
        // wrap below the buffer start
        '{32'h1000_0100, 18'd10, 18'd3, CH_2, 1'b0, '0},
        // trigger on the buffer start, empty head part
        '{32'h1000_0000, 18'd1, 18'd1, CH_3, 1'b0, '0},
        // trigger below the buffer, tail takes every pre-trigger word
        '{32'h0FFF_FF00, 18'd3, 18'd2, CH_4, 1'b0, '0},
        '{32'h0000_0000, PTS_MAX, PTS_MAX, CH_1, 1'b0, '0},
        // window ending exactly on the buffer end: no wrap
        '{32'h11E8_4760, 18'd0, 18'd1, CH_2, 1'b0, '0},
        // wrap past the buffer end
        '{32'h11E8_4760, 18'd5, 18'd2, CH_3, 1'b0, '0},
        // trigger on the buffer end, empty part up to the end
        '{32'h11E8_4800, 18'd0, 18'd1, CH_4, 1'b0, '0},
        // trigger past the buffer end
        '{32'h11E8_5000, 18'd0, 18'd4, CH_1, 1'b0, '0},
        '{32'hFFFF_FFFF, PTS_MAX, PTS_MAX, CH_INVALID_7, 1'b0, '0},
        '{32'hFFFF_FFFF, 18'd0, 18'd0, CH_INVALID_0, 1'b0, '0},
        // empty window below the buffer: three empty segments
        '{32'h0000_0000, 18'd0, 18'd0, CH_2, 1'b0, '0}
    };

    // clock, reset and ports
    logic           i_clk;
    logic           i_rst_n       = 1'b0;
    logic           start         = 1'b0;
    logic           busy;
    t_addr          i_latch_addr  = '0;
    t_pts           i_pre_points  = '0;
    t_pts           i_post_points = '0;
    t_ch            i_channel     = '0;
    logic           o_seg_valid;
    t_addr          o_seg_start;
    t_seg_words     o_seg_words;
    t_mask          o_word_mask;
    logic           o_bad_channel;
    logic           o_last;
    logic           psel          = 1'b0;
    logic           penable       = 1'b0;
    logic           pwrite        = 1'b0;
    logic [PADDR_W-1:0] paddr     = '0;
    t_addr          pwdata        = '0;
    t_addr          prdata;
    logic           pready;

    // hand-typed expectation travels with the request, so the monitor sees it at the transfer
    logic           use_typed     = 1'b0;
    t_seg           typed_due     = '0;

    // bench copy of the buffer registers
    t_addr          cfg_base      = BASE_RESET;
    t_addr          cfg_length    = LENGTH_RESET;

    t_seg           planned_segments [$];
    t_seg           seg_due;
    int             mismatch_count = 0;
    int             quiet_cycles   = 0;
    int             idle_pct       = 12;

    snapshot_segment_planner_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_latch_addr  (i_latch_addr),
        .i_pre_points  (i_pre_points),
        .i_post_points (i_post_points),
        .i_channel     (i_channel),
        .o_seg_valid   (o_seg_valid),
        .o_seg_start   (o_seg_start),
        .o_seg_words   (o_seg_words),
        .o_word_mask   (o_word_mask),
        .o_bad_channel (o_bad_channel),
        .o_last        (o_last),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("mismatch on %s: got 0x%0h, expected 0x%0h", what, got, want);
        mismatch_count++;
    endtask

    // words of each record that a channel selects: two shared header words plus
    // an eight-word block per channel, channel 1 takes the first ten words
    function automatic t_mask channel_word_mask(input t_ch ch);
        t_mask m;
        m = '0;
        case (ch)
            CH_1: m[9:0] = '1;
            CH_2: begin
                m[1:0]   = '1;
                m[17:10] = '1;
            end
            CH_3: begin
                m[1:0]   = '1;
                m[25:18] = '1;
            end
            CH_4: begin
                m[1:0]   = '1;
                m[33:26] = '1;
            end
            default: m = '0;
        endcase
        return m;
    endfunction

    function automatic void add_segment(input longint addr, input longint words,
                                        input t_mask mask, input logic bad, input logic last);
        t_seg s;
        s.start_a = t_addr'(addr);
        s.words   = (words < 0) ? '0 : t_seg_words'(words);
        s.mask    = mask;
        s.bad     = bad;
        s.last    = last;
        planned_segments.push_back(s);
    endfunction

    // split the window around the trigger into segments, all sums wide and signed
    function automatic void plan_segments(input t_addr latch_a, input t_pts pre_n,
                                          input t_pts post_n, input t_ch ch);
        longint latch, pre, post, base, len, buf_end, win_lo, win_hi;
        longint diff, head, tail, part1, part2;
        t_mask  mask;
        logic   bad;
        latch   = latch_a;
        pre     = pre_n;
        post    = post_n;
        base    = cfg_base;
        len     = cfg_length;
        buf_end = base + len;
        win_lo  = latch - pre * REC_BYTES;
        win_hi  = latch + post * REC_BYTES;
        mask    = channel_word_mask(ch);
        bad     = !(ch inside {CH_1, CH_2, CH_3, CH_4});
        if (win_lo < base) begin
            // wrap below the start: buffer tail, buffer head up to the trigger, then post part
            diff = latch - base;
            head = (diff > 0) ? (diff >> 2) : 0;
            tail = pre * REC_WORDS - head;
            if (tail < 0)
                tail = 0;
            add_segment(buf_end - tail * 4, tail, mask, bad, 1'b0);
            add_segment(base, head, mask, bad, 1'b0);
            add_segment(latch, post * REC_WORDS, mask, bad, 1'b1);
        end else if (win_hi > buf_end) begin
            // wrap past the end: pre part, trigger up to the end, then buffer head
            diff  = buf_end - latch;
            part1 = (diff > 0) ? (diff >> 2) : 0;
            part2 = post * REC_WORDS - part1;
            if (part2 < 0)
                part2 = 0;
            add_segment(win_lo, pre * REC_WORDS, mask, bad, 1'b0);
            add_segment(latch, part1, mask, bad, 1'b0);
            add_segment(base, part2, mask, bad, 1'b1);
        end else begin
            add_segment(win_lo, (pre + post) * REC_WORDS, mask, bad, 1'b1);
        end
    endfunction

    // segment check first, then the expectations of a request taken at this edge
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_seg_valid === 1'b1) begin
            if (planned_segments.size() == 0) begin
                flag_mismatch("segment with nothing pending", o_seg_start, 64'd0);
            end else begin
                seg_due = planned_segments.pop_front();
                if (o_seg_start !== seg_due.start_a)
                    flag_mismatch("seg_start", o_seg_start, seg_due.start_a);
                if (o_seg_words !== seg_due.words)
                    flag_mismatch("seg_words", o_seg_words, seg_due.words);
                if (o_word_mask !== seg_due.mask)
                    flag_mismatch("word_mask", o_word_mask, seg_due.mask);
                if (o_bad_channel !== seg_due.bad)
                    flag_mismatch("bad_channel", o_bad_channel, seg_due.bad);
                if (o_last !== seg_due.last)
                    flag_mismatch("last", o_last, seg_due.last);
            end
        end
        if (i_rst_n === 1'b1 && start === 1'b1 && busy === 1'b0) begin
            if (use_typed)
                planned_segments.push_back(typed_due);
            else
                plan_segments(i_latch_addr, i_pre_points, i_post_points, i_channel);
        end
    end

    // watchdog: any request transfer, segment or register access counts as progress
    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1 || (start === 1'b1 && busy === 1'b0)
                || o_seg_valid === 1'b1 || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("snapshot_segment_planner_top test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // random idle cycles before a request, with junk on the request fields
    task automatic sender_gap();
        while ($urandom_range(99) < idle_pct) begin
            start         <= 1'b0;
            i_latch_addr  <= $urandom;
            i_pre_points  <= t_pts'($urandom);
            i_post_points <= t_pts'($urandom);
            i_channel     <= t_ch'($urandom);
            @(posedge i_clk);
        end
    endtask

    // returns at the edge where the request transfer happens
    task automatic issue_request(input t_request req);
        sender_gap();
        start         <= 1'b1;
        i_latch_addr  <= req.latch;
        i_pre_points  <= req.pre;
        i_post_points <= req.post;
        i_channel     <= req.ch;
        use_typed     <= req.typed;
        typed_due     <= req.seg;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    // idle the request side and let every planned segment come out
    task automatic wait_drained();
        start <= 1'b0;
        while (planned_segments.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // setup and access phases, then psel and penable low before returning, so back-to-back accesses never collide
    task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] addr,
                              input t_addr wdata, output t_addr rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        rdata    = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_registers();
        t_addr rd;
        apb_access(1'b0, PADDR_BASE, '0, rd);
        if (rd !== cfg_base)
            flag_mismatch("buffer_base readback", rd, cfg_base);
        apb_access(1'b0, PADDR_LENGTH, '0, rd);
        if (rd !== cfg_length)
            flag_mismatch("buffer_length readback", rd, cfg_length);
    endtask

    task automatic set_buffer(input t_addr base, input t_addr len);
        t_addr rd;
        apb_access(1'b1, PADDR_BASE, base, rd);
        apb_access(1'b1, PADDR_LENGTH, len, rd);
        cfg_base   = base;
        cfg_length = len;
        check_registers();
    endtask

    function automatic t_pts draw_points();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 65)
            return t_pts'($urandom_range(63));
        if (r < 90)
            return t_pts'($urandom_range(4095));
        return t_pts'($urandom);
    endfunction

    // mostly triggers inside the buffer or close to its edges, some fully random
    function automatic t_request draw_request();
        t_request    req;
        int unsigned pick;
        t_addr       buf_end;
        t_addr       nudge;
        req     = '0;
        pick    = $urandom_range(99);
        buf_end = cfg_base + cfg_length;
        nudge   = t_addr'($urandom_range(1024)) - 32'd512;
        req.pre  = draw_points();
        req.post = draw_points();
        req.ch   = ($urandom_range(3) != 0) ? t_ch'($urandom_range(4, 1))
                                            : t_ch'($urandom_range(7));
        if (pick < 55)
            req.latch = cfg_base + (t_addr'($urandom_range(cfg_length)) & ~32'd3);
        else if (pick < 70)
            req.latch = cfg_base + nudge;
        else if (pick < 85)
            req.latch = buf_end + nudge;
        else
            req.latch = $urandom;
        return req;
    endfunction

    initial begin
        int    n;
        t_addr base;
        t_addr len;
        n = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // registers come out of reset at the default window
        check_registers();

        idle_pct = 12;
        for (int i = 0; i < DIRECTED_COUNT; i++)
            issue_request(DIRECTED_ROWS[i]);

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin
                    base = '0;
                    len  = '0;
                end
                1: begin
                    base = '1;
                    len  = '1;
                end
                2: begin
                    base = $urandom;
                    len  = $urandom_range(32'h4000, 32'h100);
                end
                3: begin
                    // window runs past the top of the address space
                    base = 32'hFFFF_F000;
                    len  = 32'h0000_2000;
                end
                4: begin
                    base = $urandom;
                    len  = $urandom;
                end
                default: begin
                    base = BASE_RESET;
                    len  = $urandom_range(32'h1_0000, 32'h800);
                end
            endcase
            wait_drained();
            set_buffer(base, len);
            for (int i = 0; i < PHASE_REQUESTS; i++) begin
                // sender idles rarely, then often, then never
                if (n < PHASES * PHASE_REQUESTS / 3)
                    idle_pct = 12;
                else if (n < 2 * PHASES * PHASE_REQUESTS / 3)
                    idle_pct = 87;
                else
                    idle_pct = 0;
                issue_request(draw_request());
                n++;
            end
        end

        wait_drained();
        // planned segments that never came out
        if (planned_segments.size() != 0)
            flag_mismatch("segments never issued", planned_segments.size(), 64'd0);
        if (mismatch_count == 0)
            $display("snapshot_segment_planner_top test passed");
        else
            $display("snapshot_segment_planner_top test failed");
        $finish;
    end

endmodule
